// ===== src/tnfc_pkg.sv =====
package tnfc_pkg;

  // Field widths of the item formats
  localparam int COORD_BITS       = 24;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORMAL_BITS      = NORMAL_FRAC_BITS + 2;
  // Cross product magnitudes are scaled below 2^SCALE_BITS before the root
  localparam int SCALE_BITS       = 30;
  localparam int AXES             = 3;

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic signed [NORMAL_BITS-1:0] normal_t;

  // One triangle plus view direction
  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
    coord_t view_x;
    coord_t view_y;
    coord_t view_z;
  } vert_t;

  // Normal, centroid and flags of one triangle
  typedef struct packed {
    normal_t normal_x;
    normal_t normal_y;
    normal_t normal_z;
    coord_t  center_x;
    coord_t  center_y;
    coord_t  center_z;
    logic    faces_view;
    logic    degenerate;
  } face_t;

endpackage

// ===== src/triangle_normal_facing_center.sv =====
// Triangle face normal, back-face test and centroid.
// Input channel vert (vert_valid / vert_stall) takes one triangle with its
// view vector; output channel face (face_valid / face_stall) gives the unit
// normal in Q1.14, the centroid and the faces_view / degenerate flags.
// An item is taken on an edge where valid is high and stall is low.
// The stages run in order: edges, cross product and centroid; the magnitude
// scaling; the sum of squares; the bit-per-stage square root; the three
// rounding dividers; and sign, dot product and the output register.
// Throughput is one item per clock while face_stall does not hold the
// pipeline; every stage is a register with a valid bit, and the whole
// pipeline advances together.
// When face_stall is high while a result is shown, all stages hold and
// vert_stall rises in the same cycle, so nothing is lost or repeated.
// Reset clears every valid bit at the clock edge, leaving the pipeline empty.
module triangle_normal_facing_center (
  input  logic            clk,
  input  logic            rst,
  input  logic            vert_valid,
  output logic            vert_stall,
  input  tnfc_pkg::vert_t vert,
  output logic            face_valid,
  input  logic            face_stall,
  output tnfc_pkg::face_t face
);

  localparam int CB   = tnfc_pkg::COORD_BITS;
  localparam int FB   = tnfc_pkg::NORMAL_FRAC_BITS;
  localparam int NB   = tnfc_pkg::NORMAL_BITS;
  localparam int RW   = tnfc_pkg::SCALE_BITS;
  localparam int EW   = CB + 1;
  localparam int PW   = 2 * EW;
  localparam int XW   = PW + 1;
  localparam int XMW  = (PW > RW) ? PW : RW;
  localparam int MSH  = XMW - RW;
  localparam int NS   = (MSH == 0) ? 0 : $clog2(MSH + 1);
  localparam int SQW  = 2 * RW + 2;
  localparam int LW   = SQW / 2;
  localparam int QB   = FB + 1;
  localparam int SB   = CB + 2;
  localparam int CMB  = CB + 1;
  localparam int CK   = CB + 2;
  localparam int CPW  = 2 * CMB;
  localparam int DPW  = CB + NB;
  localparam int DSW  = DPW + 2;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << CK) + 64'd2) / 64'd3;
  localparam logic [CMB-1:0] RECIP = RECIP_FULL[CMB-1:0];
  localparam tnfc_pkg::normal_t ONE = tnfc_pkg::normal_t'(1 << FB);

  // Context carried alongside the normal computation
  typedef struct packed {
    logic [2:0]                  neg;
    tnfc_pkg::coord_t [2:0]      view;
    tnfc_pkg::coord_t [2:0]      center;
    logic                        degenerate;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  logic adv;
  tnfc_pkg::coord_t [2:0] va, vb, vc, vv;

  // Stage 1: edges, coordinate sums
  logic signed [EW-1:0] s1_e1 [0:2];
  logic signed [EW-1:0] s1_e2 [0:2];
  logic signed [SB-1:0] s1_sum [0:2];
  tnfc_pkg::coord_t [2:0] s1_view;
  logic s1_vzero, s1_v;

  // Stage 2: partial products, centroid magnitudes
  logic signed [PW-1:0] s2_p [0:5];
  logic [CMB-1:0] s2_cmag [0:2];
  logic [2:0] s2_cneg;
  tnfc_pkg::coord_t [2:0] s2_view;
  logic s2_vzero, s2_v;

  // Stage 3: cross product, reciprocal products
  logic signed [XW-1:0] s3_x [0:2];
  logic [CPW-1:0] s3_cprod [0:2];
  logic [2:0] s3_cneg;
  tnfc_pkg::coord_t [2:0] s3_view;
  logic s3_vzero, s3_v;

  // Stage 4 and scaling stages
  logic [XMW-1:0] nm_mag  [0:NS][0:2];
  logic [XMW-1:0] nm_all  [0:NS];
  side_t          nm_side [0:NS];
  logic [NS:0]    nm_v;
  logic [NS:0]    nm_sh;
  logic [XMW-1:0] m4_next [0:2];
  side_t          side4_next;

  // Squares and sum
  logic [2:0][RW-1:0] q1_r;
  logic [2*RW-1:0]    q1_sq [0:2];
  side_t              q1_side;
  logic               q1_v;
  logic [2:0][RW-1:0] q2_r;
  logic [SQW-1:0]     q2_sum;
  side_t              q2_side;
  logic               q2_v;

  // Root and division
  logic               sq_v;
  logic [LW-1:0]      sq_root;
  logic [3*RW+SIDE_W-1:0] sq_tag;
  logic [2:0][RW-1:0] sq_r;
  side_t              sq_side;
  logic               dv_v;
  logic [2:0][QB-1:0] dv_q;
  logic [SIDE_W-1:0]  dv_tag;
  side_t              dv_side;

  // Signed normal, dot product
  tnfc_pkg::normal_t g_nrm [0:2];
  side_t             g_side;
  logic              g_v;
  logic signed [DPW-1:0] d1_prod [0:2];
  tnfc_pkg::normal_t d1_nrm [0:2];
  side_t             d1_side;
  logic              d1_v;
  logic signed [DSW-1:0] dot;
  logic              faces_next;

  assign va = {vert.a_z, vert.a_y, vert.a_x};
  assign vb = {vert.b_z, vert.b_y, vert.b_x};
  assign vc = {vert.c_z, vert.c_y, vert.c_x};
  assign vv = {vert.view_z, vert.view_y, vert.view_x};

  // Whole pipeline moves unless a shown result is held back
  assign adv        = !(face_valid && face_stall);
  assign vert_stall = face_valid && face_stall;

  // Stage 4 next values: magnitudes, flags, finished centroid
  always_comb begin
    side4_next.neg        = '0;
    side4_next.view       = s3_view;
    side4_next.center     = '0;
    side4_next.degenerate = s3_vzero ||
                            (s3_x[0] == '0 && s3_x[1] == '0 && s3_x[2] == '0);
    for (int i = 0; i < 3; i++) begin
      side4_next.neg[i] = s3_x[i][XW-1];
      m4_next[i] = s3_x[i][XW-1] ? XMW'(-s3_x[i]) : XMW'(s3_x[i]);
      side4_next.center[i] = s3_cneg[i] ? -CB'(s3_cprod[i] >> CK)
                                        : CB'(s3_cprod[i] >> CK);
    end
  end

  // Scaling decisions, largest shift first
  always_comb begin
    nm_sh = '0;
    for (int j = 0; j < NS; j++) begin
      nm_sh[j] = (nm_all[j] >> (RW + (1 << (NS - 1 - j)) - 1)) != '0;
    end
  end

  // Front stages and scaling
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_e1[i]  <= EW'($signed(va[i])) - EW'($signed(vb[i]));
        s1_e2[i]  <= EW'($signed(va[i])) - EW'($signed(vc[i]));
        s1_sum[i] <= SB'($signed(va[i])) + SB'($signed(vb[i])) + SB'($signed(vc[i]));
      end
      s1_view  <= vv;
      s1_vzero <= (vv == '0);

      s2_p[0] <= s1_e1[1] * s1_e2[2];
      s2_p[1] <= s1_e1[2] * s1_e2[1];
      s2_p[2] <= s1_e1[2] * s1_e2[0];
      s2_p[3] <= s1_e1[0] * s1_e2[2];
      s2_p[4] <= s1_e1[0] * s1_e2[1];
      s2_p[5] <= s1_e1[1] * s1_e2[0];
      for (int i = 0; i < 3; i++) begin
        s2_cneg[i] <= s1_sum[i][SB-1];
        s2_cmag[i] <= s1_sum[i][SB-1] ? CMB'(-s1_sum[i]) : CMB'(s1_sum[i]);
      end
      s2_view  <= s1_view;
      s2_vzero <= s1_vzero;

      for (int i = 0; i < 3; i++) begin
        s3_x[i]     <= XW'(s2_p[2*i]) - XW'(s2_p[2*i+1]);
        s3_cprod[i] <= s2_cmag[i] * RECIP;
      end
      s3_cneg  <= s2_cneg;
      s3_view  <= s2_view;
      s3_vzero <= s2_vzero;

      for (int i = 0; i < 3; i++) begin
        nm_mag[0][i] <= m4_next[i];
      end
      nm_all[0]  <= m4_next[0] | m4_next[1] | m4_next[2];
      nm_side[0] <= side4_next;

      for (int j = 0; j < NS; j++) begin
        for (int i = 0; i < 3; i++) begin
          nm_mag[j+1][i] <= nm_sh[j] ? (nm_mag[j][i] >> (1 << (NS - 1 - j)))
                                     : nm_mag[j][i];
        end
        nm_all[j+1]  <= nm_sh[j] ? (nm_all[j] >> (1 << (NS - 1 - j))) : nm_all[j];
        nm_side[j+1] <= nm_side[j];
      end
    end
  end

  // Squares, sum, sign, dot product, output register
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        q1_r[i]  <= nm_mag[NS][i][RW-1:0];
        q1_sq[i] <= nm_mag[NS][i][RW-1:0] * nm_mag[NS][i][RW-1:0];
      end
      q1_side <= nm_side[NS];

      q2_r    <= q1_r;
      q2_sum  <= SQW'(q1_sq[0]) + SQW'(q1_sq[1]) + SQW'(q1_sq[2]);
      q2_side <= q1_side;

      for (int i = 0; i < 3; i++) begin
        if (dv_side.degenerate) begin
          g_nrm[i] <= '0;
        end else if (dv_side.neg[i]) begin
          g_nrm[i] <= -$signed({1'b0, dv_q[i]});
        end else begin
          g_nrm[i] <= $signed({1'b0, dv_q[i]});
        end
      end
      g_side <= dv_side;

      for (int i = 0; i < 3; i++) begin
        d1_prod[i] <= $signed(g_side.view[i]) * g_nrm[i];
      end
      d1_nrm  <= g_nrm;
      d1_side <= g_side;

      face.normal_x   <= d1_nrm[0];
      face.normal_y   <= d1_nrm[1];
      face.normal_z   <= d1_nrm[2];
      face.center_x   <= d1_side.center[0];
      face.center_y   <= d1_side.center[1];
      face.center_z   <= d1_side.center[2];
      face.faces_view <= faces_next;
      face.degenerate <= d1_side.degenerate;
    end
  end

  // Dot product sign; a degenerate item never faces the view
  always_comb begin
    dot = DSW'(d1_prod[0]) + DSW'(d1_prod[1]) + DSW'(d1_prod[2]);
    faces_next = !d1_side.degenerate && (dot[DSW-1] || dot == '0);
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      s3_v       <= 1'b0;
      nm_v       <= '0;
      q1_v       <= 1'b0;
      q2_v       <= 1'b0;
      g_v        <= 1'b0;
      d1_v       <= 1'b0;
      face_valid <= 1'b0;
    end else if (adv) begin
      s1_v       <= vert_valid;
      s2_v       <= s1_v;
      s3_v       <= s2_v;
      nm_v[0]    <= s3_v;
      for (int j = 0; j < NS; j++) begin
        nm_v[j+1] <= nm_v[j];
      end
      q1_v       <= nm_v[NS];
      q2_v       <= q1_v;
      g_v        <= dv_v;
      d1_v       <= g_v;
      face_valid <= d1_v;
    end
  end

  tnfc_sqrt #(
    .RAD_W (SQW),
    .TAG_W (3 * RW + SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (q2_v),
    .in_rad    (q2_sum),
    .in_tag    ({q2_r, q2_side}),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  assign {sq_r, sq_side} = sq_tag;

  tnfc_div #(
    .RW    (RW),
    .LW    (LW),
    .QB    (QB),
    .TAG_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sq_v),
    .in_r      (sq_r),
    .in_len    (sq_root),
    .in_tag    (sq_side),
    .out_valid (dv_v),
    .out_q     (dv_q),
    .out_tag   (dv_tag)
  );

  assign dv_side = side_t'(dv_tag);

  // A degenerate result carries a zero normal and no facing flag
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (face_valid && face.degenerate) |->
      (face.normal_x == '0 && face.normal_y == '0 && face.normal_z == '0 &&
       !face.faces_view))
    else $error("degenerate result with nonzero normal or facing set");

  // Normal components never exceed one
  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    face_valid |->
      (face.normal_x <= ONE && face.normal_x >= -ONE &&
       face.normal_y <= ONE && face.normal_y >= -ONE &&
       face.normal_z <= ONE && face.normal_z >= -ONE))
    else $error("normal component out of range");

  // A proper triangle always gets a nonzero normal
  a_normal_nonzero: assert property (@(posedge clk) disable iff (rst)
    (face_valid && !face.degenerate) |->
      (face.normal_x != '0 || face.normal_y != '0 || face.normal_z != '0))
    else $error("zero normal on a proper triangle");

endmodule

// ===== src/tnfc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// The tag rides along unchanged so the caller keeps its context aligned.
module tnfc_sqrt #(
  parameter int RAD_W = 62,
  parameter int TAG_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [RAD_W-1:0]     in_rad,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  output logic [RAD_W/2-1:0]   out_root,
  output logic [TAG_W-1:0]     out_tag
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic [RAD_W-1:0]  rad  [0:ROOT_W-1];
  logic [REM_W-1:0]  rem  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root [0:ROOT_W-1];
  logic [TAG_W-1:0]  tag  [0:ROOT_W-1];
  logic [ROOT_W-1:0] vld;

  logic [REM_W+ROOT_W-1:0] step_next [0:ROOT_W-1];

  // One digit of the recurrence: bring down two bits, try 4*root+1
  function automatic logic [REM_W+ROOT_W-1:0] sq_step(
    input logic [REM_W-1:0]  rem_in,
    input logic [ROOT_W-1:0] root_in,
    input logic [1:0]        bits_in
  );
    logic [REM_W-1:0] cat;
    logic [REM_W-1:0] trial;
    cat   = {rem_in[REM_W-3:0], bits_in};
    trial = {root_in, 2'b01};
    if (cat >= trial) begin
      sq_step = {cat - trial, root_in[ROOT_W-2:0], 1'b1};
    end else begin
      sq_step = {cat, root_in[ROOT_W-2:0], 1'b0};
    end
  endfunction

  // Step logic per stage
  always_comb begin
    step_next[0] = sq_step('0, '0, in_rad[RAD_W-1:RAD_W-2]);
    for (int k = 1; k < ROOT_W; k++) begin
      step_next[k] = sq_step(rem[k-1], root[k-1], rad[k-1][RAD_W-1:RAD_W-2]);
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      rad[0]              <= in_rad << 2;
      {rem[0], root[0]}   <= step_next[0];
      tag[0]              <= in_tag;
      for (int k = 1; k < ROOT_W; k++) begin
        rad[k]            <= rad[k-1] << 2;
        {rem[k], root[k]} <= step_next[k];
        tag[k]            <= tag[k-1];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ROOT_W-2:0], in_valid};
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_tag   = tag[ROOT_W-1];

endmodule

// ===== src/tnfc_div.sv =====
// Three-lane pipelined rounding divider: q = (r * 2^(QB-1) + len/2) / len.
// A prep stage forms the numerator, then one quotient bit per stage.
module tnfc_div #(
  parameter int RW    = 30,
  parameter int LW    = 31,
  parameter int QB    = 15,
  parameter int TAG_W = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [2:0][RW-1:0]       in_r,
  input  logic [LW-1:0]            in_len,
  input  logic [TAG_W-1:0]         in_tag,
  output logic                     out_valid,
  output logic [2:0][QB-1:0]       out_q,
  output logic [TAG_W-1:0]         out_tag
);

  localparam int FB   = QB - 1;
  localparam int NUMW = RW + QB;

  logic [2:0][LW-1:0] rem  [0:QB];
  logic [2:0][QB-1:0] lo   [0:QB];
  logic [LW-1:0]      len  [0:QB];
  logic [TAG_W-1:0]   tag  [0:QB];
  logic [QB:0]        vld;

  logic [2:0][NUMW-1:0]  num;
  logic [LW+QB-1:0]      step_next [0:QB-1][0:2];
  logic                  rem_ok;

  // Shift in one numerator bit, subtract the divisor if it fits
  function automatic logic [LW+QB-1:0] dv_step(
    input logic [LW-1:0] rem_in,
    input logic [QB-1:0] lo_in,
    input logic [LW-1:0] len_in
  );
    logic [LW:0] t;
    logic [LW:0] diff;
    t    = {rem_in, lo_in[QB-1]};
    diff = t - {1'b0, len_in};
    if (t >= {1'b0, len_in}) begin
      dv_step = {diff[LW-1:0], lo_in[QB-2:0], 1'b1};
    end else begin
      dv_step = {t[LW-1:0], lo_in[QB-2:0], 1'b0};
    end
  endfunction

  // Numerator with half the divisor added for rounding
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {in_r[i], {FB{1'b0}}} + NUMW'(in_len >> 1);
    end
  end

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      for (int i = 0; i < 3; i++) begin
        step_next[k][i] = dv_step(rem[k][i], lo[k][i], len[k]);
      end
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= {{(LW-RW){1'b0}}, num[i][NUMW-1:QB]};
        lo[0][i]  <= num[i][QB-1:0];
      end
      len[0] <= in_len;
      tag[0] <= in_tag;
      for (int k = 0; k < QB; k++) begin
        for (int i = 0; i < 3; i++) begin
          {rem[k+1][i], lo[k+1][i]} <= step_next[k][i];
        end
        len[k+1] <= len[k];
        tag[k+1] <= tag[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QB-1:0], in_valid};
    end
  end

  assign out_valid = vld[QB];
  assign out_q     = lo[QB];
  assign out_tag   = tag[QB];

  always_comb begin
    rem_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (rem[QB][i] >= len[QB]) rem_ok = 1'b0;
    end
  end

  // With a nonzero divisor, every final remainder stays below the divisor
  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    (vld[QB] && len[QB] != '0) |-> rem_ok)
    else $error("divider remainder not below divisor");

endmodule

// ===== tb/triangle_normal_facing_center_tb.sv =====
module triangle_normal_facing_center_tb;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            vert_valid = 1'b0;
  logic            vert_stall;
  tnfc_pkg::vert_t vert = '0;
  logic            face_valid;
  logic            face_stall = 1'b0;
  tnfc_pkg::face_t face;

  tnfc_pkg::face_t expected_faces[$];
  int    n_errors = 0;
  int    n_faces = 0;
  int    n_sent = 0;
  int    n_degen = 0;
  int    n_facing = 0;
  int    hold_cycles = 0;
  int    rx_wait = 0;
  int    rx_gap = 0;
  bit    random_stall = 1'b0;

  always #5 clk = ~clk;

  triangle_normal_facing_center u_top (
    .clk(clk), .rst(rst),
    .vert_valid(vert_valid), .vert_stall(vert_stall), .vert(vert),
    .face_valid(face_valid), .face_stall(face_stall), .face(face)
  );

  // Magnitude of a 64-bit signed value
  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? -a : a;
  endfunction

  // Integer square root, floor
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Normal, centroid and flags of one triangle
  function automatic tnfc_pkg::face_t face_of(input tnfc_pkg::vert_t t);
    logic signed [63:0]  p[9];
    logic signed [63:0]  e1[3], e2[3], nq[3], sum3;
    logic signed [127:0] cr[3], dot;
    logic [127:0]        mg[3], all_bits;
    logic [63:0]         r[3], sq, len, q;
    int                  bl, s;
    bit                  degen;
    tnfc_pkg::face_t     f;
    p[0] = t.a_x; p[1] = t.a_y; p[2] = t.a_z;
    p[3] = t.b_x; p[4] = t.b_y; p[5] = t.b_z;
    p[6] = t.c_x; p[7] = t.c_y; p[8] = t.c_z;
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[i] - p[3+i];
      e2[i] = p[i] - p[6+i];
      nq[i] = 0;
    end
    cr[0] = 128'(e1[1]) * 128'(e2[2]) - 128'(e1[2]) * 128'(e2[1]);
    cr[1] = 128'(e1[2]) * 128'(e2[0]) - 128'(e1[0]) * 128'(e2[2]);
    cr[2] = 128'(e1[0]) * 128'(e2[1]) - 128'(e1[1]) * 128'(e2[0]);
    degen = (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) ||
            (t.view_x == 0 && t.view_y == 0 && t.view_z == 0);
    f = '0;
    if (!degen) begin
      all_bits = 0;
      for (int i = 0; i < 3; i++) begin
        mg[i] = cr[i][127] ? -cr[i] : cr[i];
        all_bits = all_bits | mg[i];
      end
      bl = 0;
      for (int b = 0; b < 128; b++) if (all_bits[b]) bl = b + 1;
      s = bl > tnfc_pkg::SCALE_BITS ? bl - tnfc_pkg::SCALE_BITS : 0;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        r[i] = 64'(mg[i] >> s);
        sq = sq + r[i] * r[i];
      end
      len = root_floor(sq);
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        q = ((r[i] << tnfc_pkg::NORMAL_FRAC_BITS) + (len >> 1)) / len;
        nq[i] = cr[i][127] ? -$signed(q) : $signed(q);
      end
      dot = 128'(signed'(t.view_x)) * 128'(nq[0]) + 128'(signed'(t.view_y)) * 128'(nq[1])
          + 128'(signed'(t.view_z)) * 128'(nq[2]);
      f.faces_view = dot <= 0;
    end
    f.normal_x = nq[0][tnfc_pkg::NORMAL_BITS-1:0];
    f.normal_y = nq[1][tnfc_pkg::NORMAL_BITS-1:0];
    f.normal_z = nq[2][tnfc_pkg::NORMAL_BITS-1:0];
    // SystemVerilog signed division truncates toward zero
    sum3 = p[0] + p[3] + p[6]; f.center_x = 24'(sum3 / 3);
    sum3 = p[1] + p[4] + p[7]; f.center_y = 24'(sum3 / 3);
    sum3 = p[2] + p[5] + p[8]; f.center_z = 24'(sum3 / 3);
    f.degenerate = degen;
    return f;
  endfunction

  // Send one item after an optional gap; record expectation at acceptance.
  // Valid stays high after acceptance so back-to-back items need no gap;
  // the gap or the drain drops it.
  task automatic send_tri(input tnfc_pkg::vert_t t, input int gap);
    if (gap > 0) begin
      vert_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vert <= t;
    vert_valid <= 1'b1;
    do @(posedge clk); while (vert_stall);
    expected_faces.push_back(face_of(t));
    n_sent++;
  endtask

  task automatic wait_drain();
    vert_valid <= 1'b0;
    while (expected_faces.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // Receiver stall: long hold when requested, else in random mode a random wait, possibly none, after each item
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      face_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_wait > 0) begin
      face_stall <= 1'b1;
      rx_wait <= rx_wait - 1;
    end else if (random_stall && face_valid && !face_stall) begin
      rx_gap = $urandom_range(0, 6);
      face_stall <= (rx_gap != 0);
      rx_wait <= (rx_gap != 0) ? rx_gap - 1 : 0;
    end else begin
      face_stall <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && face_valid && !face_stall) begin
      n_faces++;
      if (expected_faces.size() == 0) begin
        $display("%0t: unexpected result %h", $time, face);
        n_errors++;
      end else begin
        tnfc_pkg::face_t e;
        e = expected_faces.pop_front();
        if (face.degenerate) n_degen++;
        if (face.faces_view) n_facing++;
        if (face.normal_x !== e.normal_x)
          $display("%0t: normal_x exp %0d got %0d", $time, e.normal_x, face.normal_x);
        if (face.normal_y !== e.normal_y)
          $display("%0t: normal_y exp %0d got %0d", $time, e.normal_y, face.normal_y);
        if (face.normal_z !== e.normal_z)
          $display("%0t: normal_z exp %0d got %0d", $time, e.normal_z, face.normal_z);
        if (face.center_x !== e.center_x)
          $display("%0t: center_x exp %0d got %0d", $time, e.center_x, face.center_x);
        if (face.center_y !== e.center_y)
          $display("%0t: center_y exp %0d got %0d", $time, e.center_y, face.center_y);
        if (face.center_z !== e.center_z)
          $display("%0t: center_z exp %0d got %0d", $time, e.center_z, face.center_z);
        if (face.faces_view !== e.faces_view)
          $display("%0t: faces_view exp %0b got %0b", $time, e.faces_view, face.faces_view);
        if (face.degenerate !== e.degenerate)
          $display("%0t: degenerate exp %0b got %0b", $time, e.degenerate, face.degenerate);
        if (face !== e) n_errors++;
      end
    end
  end

  function automatic tnfc_pkg::coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return tnfc_pkg::coord_t'($urandom);
      1: return 24'sh7FFFFF;
      2: return 24'sh800000;
      3: return tnfc_pkg::coord_t'($signed($urandom_range(0, 20)) - 10);
      default: return tnfc_pkg::coord_t'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic tnfc_pkg::vert_t rand_tri();
    tnfc_pkg::vert_t t;
    t = tnfc_pkg::vert_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom});
    t.a_x = rand_coord(); t.b_y = rand_coord(); t.c_z = rand_coord();
    t.view_y = rand_coord();
    case ($urandom_range(0, 9))
      0: begin t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z; end  // repeated vertex
      1: begin t.view_x = 0; t.view_y = 0; t.view_z = 0; end     // zero view
      2: begin                                                   // collinear
        t.c_x = t.b_x; t.c_y = t.b_y; t.c_z = t.b_z;
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic tnfc_pkg::vert_t mk(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                         vx, vy, vz);
    tnfc_pkg::vert_t t;
    t = {tnfc_pkg::coord_t'(ax), tnfc_pkg::coord_t'(ay), tnfc_pkg::coord_t'(az),
         tnfc_pkg::coord_t'(bx), tnfc_pkg::coord_t'(by), tnfc_pkg::coord_t'(bz),
         tnfc_pkg::coord_t'(cx), tnfc_pkg::coord_t'(cy), tnfc_pkg::coord_t'(cz),
         tnfc_pkg::coord_t'(vx), tnfc_pkg::coord_t'(vy), tnfc_pkg::coord_t'(vz)};
    return t;
  endfunction

  // Extremes, axis-aligned faces, degenerate cases, dot exactly zero
  task automatic test_directed();
    int mx, mn;
    mx = 8388607; mn = -8388608;
    send_tri('0, 0);
    send_tri('1, 0);
    send_tri(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 256), 0);
    send_tri(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, -256), 1);
    send_tri(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 0), 0);
    send_tri(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0), 0);
    send_tri(mk(5, 5, 5, 5, 5, 5, 9, 1, 3, 1, 1, 1), 2);
    send_tri(mk(0, 0, 0, 1, 1, 1, 2, 2, 2, 1, 0, 0), 0);
    send_tri(mk(mx, mx, mx, mn, mn, mn, mx, mn, mx, mx, mx, mx), 0);
    send_tri(mk(mn, mx, mn, mx, mn, mx, mn, mn, mx, mn, mn, mn), 0);
    send_tri(mk(mx, 0, 0, 0, mx, 0, 0, 0, mx, mn, 0, mx), 0);
    send_tri(mk(mn, mn, mn, mx, mx, mx, mx, mx, mx, 1, 1, 1), 0);
    send_tri(mk(mn, 0, mx, mx, mn, 0, 0, mx, mn, -1, -1, -1), 0);
    send_tri(mk(-1, -2, -4, 1, 2, 0, -5, 7, 0, 3, -3, 1), 0);
    send_tri(mk(0, 0, 0, 1, 0, 0, 0, 1, 0, mx, mn, 1), 0);
    send_tri(mk(-1, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0);
    send_tri(mk(1, 2, 3, 7, 5, 11, 2, 9, 4, mn, mx, mn), 3);
    wait_drain();
  endtask

  // Random items with random gaps and random receiver stalls
  task automatic test_random(input int count);
    random_stall = 1'b1;
    for (int i = 0; i < count; i++) send_tri(rand_tri(), $urandom_range(0, 6));
    random_stall = 1'b0;
    wait_drain();
  endtask

  // Receiver holds off long enough that the pipeline fills and backs up
  task automatic test_backpressure();
    hold_cycles = 150;
    for (int i = 0; i < 100; i++)
      send_tri(rand_tri(), (i % 20 < 12) ? 0 : $urandom_range(0, 6));
    wait_drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250);
    test_backpressure();
    test_random(250);
    $display("Sent %0d triangles, checked %0d results (%0d degenerate, %0d facing)",
             n_sent, n_faces, n_degen, n_facing);
    if (n_errors == 0 && expected_faces.size() == 0) begin
      $display("PASS triangle_normal_facing_center");
    end else begin
      $display("FAIL triangle_normal_facing_center");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL triangle_normal_facing_center");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tnfc_pkg.sv
src/tnfc_sqrt.sv
src/tnfc_div.sv
src/triangle_normal_facing_center.sv
tb/triangle_normal_facing_center_tb.sv
